/* rtl/assert_macros.svh */
// Assertion helper macros used by the port checker, tga_checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tga_pkg.sv */
// Shared types and constants of the TGA RLE decoder.
// No dependencies; imported by every module of the block.
package tga_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RUN    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SIGNATURE = 2'd1;
  localparam logic [1:0] ERR_HEADER    = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  // Signature: 12 bytes, all zero except the image type byte
  localparam logic [3:0] SIG_TYPE_POS   = 4'd2;
  localparam logic [3:0] SIG_LAST_POS   = 4'd11;
  localparam logic [3:0] SIG_LEN        = 4'd12;
  localparam logic [7:0] SIG_PLAIN_TYPE = 8'd2;
  localparam logic [7:0] SIG_RLE_TYPE   = 8'd10;

  // Signature kind bits: bit0 uncompressed still possible, bit1 RLE still possible
  localparam logic [1:0] SK_BOTH  = 2'b11;
  localparam logic [1:0] SK_PLAIN = 2'b01;
  localparam logic [1:0] SK_RLE   = 2'b10;
  localparam logic [1:0] SK_NONE  = 2'b00;

  // Header byte positions (counted from file start)
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  localparam logic [7:0] BPP_24 = 8'd24;
  localparam logic [7:0] BPP_32 = 8'd32;

  // RLE packet header: below this is a raw packet
  localparam logic [7:0] PKT_REPEAT_FLAG = 8'd128;
  localparam logic [7:0] PKT_REPEAT_BIAS = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } tga_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        is_compressed;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [1:0]  error_code;
    logic        last;
  } tga_out_t;

  // Raw event from the parser; color holds the stored bytes B,G,R,A in slots 0..3
  typedef struct packed {
    logic [1:0]      kind;
    logic [15:0]     image_width;
    logic [15:0]     image_height;
    logic            has_alpha;
    logic            is_compressed;
    logic [3:0][7:0] color;
    logic [7:0]      count;
    logic [1:0]      error_code;
    logic            last;
  } tga_evt_t;

endpackage

/* rtl/tga_parser.sv */
// Front end: takes file bytes, runs the signature/header/packet parser and
// produces at most one raw event per byte. Depends on tga_pkg.
module tga_parser import tga_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  tga_in_t  src_data,
  output logic     src_stall,
  input  logic     q_full,
  output logic     evt_push,
  output tga_evt_t evt
);

  localparam int PC = PIXEL_COUNT_BITS;

  typedef enum logic [2:0] {
    PH_SIG, PH_HDR, PH_PKT, PH_COLOR, PH_DONE, PH_ERR
  } phase_t;

  phase_t          phase, phase_next;
  logic [4:0]      hdr_idx, hdr_idx_next;
  logic [1:0]      sig_kind, sig_kind_next;
  logic [15:0]     width_reg, width_next;
  logic [15:0]     height_reg, height_next;
  logic            alpha_mode, alpha_next;
  logic [PC-1:0]   pixels_left, pixels_next;
  logic [7:0]      packet_left, packet_next;
  logic            packet_rep, packet_rep_next;
  logic [1:0]      color_idx, color_idx_next;
  logic [7:0]      color_bytes [4];
  logic [7:0]      color_next [4];

  // state as seen by this byte (start_of_file restarts the parser first)
  phase_t          eff_phase;
  logic [4:0]      eff_hdr_idx;
  logic [1:0]      eff_sig_kind;
  logic [15:0]     eff_width, eff_height;
  logic            eff_alpha;
  logic [PC-1:0]   eff_pixels;

  logic [7:0]      b;
  logic            sof;
  logic            accept;
  logic [31:0]     product;
  logic            overflow;
  logic            hdr_bad;
  logic [7:0]      exp_plain, exp_rle;
  logic [1:0]      cidx_inc;
  logic            pixel_done;
  logic [PC-1:0]   run_len;

  logic            emit;
  logic [1:0]      e_kind, e_err;
  logic [7:0]      e_cnt;
  logic            e_last;

  assign b         = src_data.data_byte;
  assign sof       = src_data.start_of_file;
  assign src_stall = q_full;
  assign accept    = src_valid && !src_stall;
  assign evt_push  = accept && emit;

  assign eff_phase    = sof ? PH_SIG  : phase;
  assign eff_hdr_idx  = sof ? 5'd0    : hdr_idx;
  assign eff_sig_kind = sof ? SK_BOTH : sig_kind;
  assign eff_width    = sof ? 16'd0   : width_reg;
  assign eff_height   = sof ? 16'd0   : height_reg;
  assign eff_alpha    = sof ? 1'b0    : alpha_mode;
  assign eff_pixels   = sof ? '0      : pixels_left;

  // pixel count check, only used at the depth byte where both dims are registered
  assign product = width_reg * height_reg;
  always_comb begin
    if (PC < 32) begin
      overflow = (product >> PC) != 32'd0;
    end else begin
      overflow = 1'b0;
    end
  end
  assign hdr_bad = (width_reg == 16'd0) || (height_reg == 16'd0) ||
                   ((b != BPP_24) && (b != BPP_32)) || overflow;

  assign exp_plain = (eff_hdr_idx[3:0] == SIG_TYPE_POS) ? SIG_PLAIN_TYPE : 8'd0;
  assign exp_rle   = (eff_hdr_idx[3:0] == SIG_TYPE_POS) ? SIG_RLE_TYPE   : 8'd0;

  assign cidx_inc   = color_idx + 2'd1;
  // 24 bpp ends after slot 2, 32 bpp after slot 3
  assign pixel_done = (cidx_inc == 2'd0) || (!alpha_mode && (cidx_inc == 2'd3));
  assign run_len    = {{(PC-8){1'b0}}, packet_left};

  always_comb begin
    phase_next      = eff_phase;
    hdr_idx_next    = eff_hdr_idx;
    sig_kind_next   = eff_sig_kind;
    width_next      = eff_width;
    height_next     = eff_height;
    alpha_next      = eff_alpha;
    pixels_next     = eff_pixels;
    packet_next     = sof ? 8'd0 : packet_left;
    packet_rep_next = sof ? 1'b0 : packet_rep;
    color_idx_next  = sof ? 2'd0 : color_idx;
    for (int k = 0; k < 4; k++) begin
      color_next[k] = color_bytes[k];
    end
    emit   = 1'b0;
    e_kind = KIND_HEADER;
    e_err  = ERR_NONE;
    e_cnt  = 8'd0;
    e_last = 1'b0;

    case (eff_phase)
      PH_SIG: begin
        if (eff_hdr_idx[3:0] < SIG_LEN) begin
          if (b != exp_plain) sig_kind_next[0] = 1'b0;
          if (b != exp_rle)   sig_kind_next[1] = 1'b0;
        end
        hdr_idx_next = eff_hdr_idx + 5'd1;
        if (eff_hdr_idx[3:0] >= SIG_LAST_POS) begin
          if (sig_kind_next == SK_NONE) begin
            phase_next = PH_ERR;
            emit       = 1'b1;
            e_kind     = KIND_ERROR;
            e_err      = ERR_SIGNATURE;
          end else begin
            phase_next   = PH_HDR;
            hdr_idx_next = HDR_WIDTH_LO;
          end
        end
      end
      PH_HDR: begin
        case (hdr_idx)
          HDR_WIDTH_LO: begin
            width_next   = {8'd0, b};
            hdr_idx_next = hdr_idx + 5'd1;
          end
          HDR_WIDTH_HI: begin
            width_next   = {b, width_reg[7:0]};
            hdr_idx_next = hdr_idx + 5'd1;
          end
          HDR_HEIGHT_LO: begin
            height_next  = {8'd0, b};
            hdr_idx_next = hdr_idx + 5'd1;
          end
          HDR_HEIGHT_HI: begin
            height_next  = {b, height_reg[7:0]};
            hdr_idx_next = hdr_idx + 5'd1;
          end
          HDR_DEPTH: begin
            hdr_idx_next = HDR_DESC;
            emit         = 1'b1;
            if (hdr_bad) begin
              phase_next = PH_ERR;
              e_kind     = KIND_ERROR;
              e_err      = ERR_HEADER;
            end else begin
              alpha_next  = (b == BPP_32);
              pixels_next = product[PC-1:0];
              e_kind      = KIND_HEADER;
            end
          end
          default: begin
            // descriptor byte is skipped; pixel data follows
            color_idx_next  = 2'd0;
            packet_rep_next = 1'b0;
            packet_next     = 8'd0;
            phase_next      = (sig_kind == SK_RLE) ? PH_PKT : PH_COLOR;
          end
        endcase
      end
      PH_PKT: begin
        if (b < PKT_REPEAT_FLAG) begin
          packet_rep_next = 1'b0;
          packet_next     = b + 8'd1;
        end else begin
          packet_rep_next = 1'b1;
          packet_next     = b - PKT_REPEAT_BIAS;
        end
        color_idx_next = 2'd0;
        phase_next     = PH_COLOR;
      end
      PH_COLOR: begin
        color_next[color_idx] = b;
        if (!pixel_done) begin
          color_idx_next = cidx_inc;
        end else begin
          color_idx_next = 2'd0;
          emit           = 1'b1;
          e_kind         = KIND_RUN;
          e_cnt          = 8'd1;
          if (sig_kind != SK_RLE) begin
            pixels_next = pixels_left - 1'b1;
            if (pixels_next == '0) begin
              phase_next = PH_DONE;
              e_last     = 1'b1;
            end
          end else if (packet_rep) begin
            if (run_len > pixels_left) begin
              phase_next = PH_ERR;
              e_kind     = KIND_ERROR;
              e_err      = ERR_OVERRUN;
              e_cnt      = 8'd0;
            end else begin
              pixels_next = pixels_left - run_len;
              packet_next = 8'd0;
              e_cnt       = packet_left;
              if (pixels_next == '0) begin
                phase_next = PH_DONE;
                e_last     = 1'b1;
              end else begin
                phase_next = PH_PKT;
              end
            end
          end else if (pixels_left == '0) begin
            phase_next = PH_ERR;
            e_kind     = KIND_ERROR;
            e_err      = ERR_OVERRUN;
            e_cnt      = 8'd0;
          end else begin
            pixels_next = pixels_left - 1'b1;
            packet_next = packet_left - 8'd1;
            // last is flagged only when the packet ends with the image
            if (packet_next == 8'd0) begin
              if (pixels_next == '0) begin
                phase_next = PH_DONE;
                e_last     = 1'b1;
              end else begin
                phase_next = PH_PKT;
              end
            end
          end
        end
      end
      default: begin
        // done or error: bytes are dropped until the next start of file
      end
    endcase

    evt.kind          = e_kind;
    evt.image_width   = width_next;
    evt.image_height  = height_next;
    evt.has_alpha     = alpha_next;
    evt.is_compressed = (sig_kind_next == SK_RLE);
    for (int k = 0; k < 4; k++) begin
      evt.color[k] = color_next[k];
    end
    evt.count      = e_cnt;
    evt.error_code = e_err;
    evt.last       = e_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SIG;
      hdr_idx     <= 5'd0;
      sig_kind    <= SK_BOTH;
      width_reg   <= 16'd0;
      height_reg  <= 16'd0;
      alpha_mode  <= 1'b0;
      pixels_left <= '0;
      packet_left <= 8'd0;
      packet_rep  <= 1'b0;
      color_idx   <= 2'd0;
    end else if (accept) begin
      phase       <= phase_next;
      hdr_idx     <= hdr_idx_next;
      sig_kind    <= sig_kind_next;
      width_reg   <= width_next;
      height_reg  <= height_next;
      alpha_mode  <= alpha_next;
      pixels_left <= pixels_next;
      packet_left <= packet_next;
      packet_rep  <= packet_rep_next;
      color_idx   <= color_idx_next;
    end
  end

  // pixel byte store, written only in the color phase
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        color_bytes[k] <= color_next[k];
      end
    end
  end

endmodule

/* rtl/tga_queue.sv */
// Two-entry event queue between the parser and the output stage.
// Depends on tga_pkg for the event type.
module tga_queue import tga_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tga_evt_t push_data,
  output logic     full,
  input  logic     pop,
  output tga_evt_t pop_data,
  output logic     empty
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  tga_evt_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/tga_out_stage.sv */
// Back end: pops raw events, maps stored bytes to color channels and holds
// the result register. Depends on tga_pkg.
module tga_out_stage import tga_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  tga_evt_t q_data,
  output logic     q_pop,
  output logic     res_valid,
  input  logic     res_stall,
  output tga_out_t res_data
);

  logic     take;
  logic     is_run;
  tga_out_t fmt;

  assign take   = !res_valid || !res_stall;
  assign q_pop  = take && !q_empty;
  assign is_run = (q_data.kind == KIND_RUN);

  // stored order is B,G,R,A; channels are zero outside pixel runs
  always_comb begin
    fmt.kind          = q_data.kind;
    fmt.image_width   = q_data.image_width;
    fmt.image_height  = q_data.image_height;
    fmt.has_alpha     = q_data.has_alpha;
    fmt.is_compressed = q_data.is_compressed;
    fmt.red           = is_run ? q_data.color[2] : 8'd0;
    fmt.green         = is_run ? q_data.color[1] : 8'd0;
    fmt.blue          = is_run ? q_data.color[0] : 8'd0;
    fmt.alpha         = (is_run && q_data.has_alpha) ? q_data.color[3] : 8'd0;
    fmt.repeat_count  = q_data.count;
    fmt.error_code    = q_data.error_code;
    fmt.last          = q_data.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_data <= fmt;
  end

endmodule

/* rtl/tga_rle_image_decoder_unit.sv */
// Top level of the TGA RLE decoder (24/32 bpp).
// Depends on tga_pkg, tga_parser, tga_queue and tga_out_stage.
//
// Usage:
//   src channel: one file byte per beat (data_byte, start_of_file). A beat
//     with start_of_file set restarts the parser before that byte is parsed.
//   res channel: header, pixel-run and error results, at most one per byte.
//   Both channels: a beat moves when valid is high and stall is low.
// Throughput: one byte per cycle, sustained, while res_stall stays low.
//   The parser derives its whole new state from the current byte.
// Result path: an accepted byte's event is written into the queue and then
//   loaded from there into the result register, which raises res_valid.
// Receiver stall: the result register holds its beat; the queue absorbs two
//   more results, then src_stall rises (it follows the queue fill only).
//   Bytes that produce no result still need a free queue slot to be taken.
// Reset (rst, synchronous): parser back to signature search, queue and
//   result register emptied. No memory sweep; the block takes bytes at once.
// After an error or the last run, bytes are dropped silently until a beat
//   with start_of_file arrives.
module tga_rle_image_decoder_unit import tga_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  tga_in_t  src_data,
  output logic     res_valid,
  input  logic     res_stall,
  output tga_out_t res_data
);

  logic     q_full, q_empty, q_push, q_pop;
  tga_evt_t q_wdata, q_rdata;

  // front: byte parser
  tga_parser #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_data  (src_data),
    .src_stall (src_stall),
    .q_full    (q_full),
    .evt_push  (q_push),
    .evt       (q_wdata)
  );

  // decoupling queue
  tga_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: channel mapping and result register
  tga_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

/* rtl/tga_checker.sv */
// Port-level checks for the TGA decoder, bound to the top level.
// Depends on tga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tga_checker import tga_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     res_valid,
  input logic     res_stall,
  input tga_out_t res_data
);

  // stalled result beat stays put
  `ASSERT_DIS(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid && $stable(res_data), "result changed while stalled")

  // a run carries a real count and no error code
  `ASSERT_DIS(a_run_fields, clk, rst, res_valid && res_data.kind == KIND_RUN |-> res_data.repeat_count != 8'd0 && res_data.error_code == ERR_NONE, "bad run fields")

  // errors carry a code, zero red and zero count, and never end the image
  `ASSERT_DIS(a_err_fields, clk, rst, res_valid && res_data.kind == KIND_ERROR |-> res_data.error_code != ERR_NONE && !res_data.last && res_data.red == 8'd0 && res_data.repeat_count == 8'd0, "bad error fields")

  // header result only for a nonzero image
  `ASSERT_DIS(a_hdr_dims, clk, rst, res_valid && res_data.kind == KIND_HEADER |-> res_data.image_width != 16'd0 && res_data.image_height != 16'd0 && !res_data.last, "bad header result")

  // result register is empty right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind tga_rle_image_decoder_unit tga_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

/* verif/tga_decode_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the TGA RLE decoder: predicts results from accepted file bytes
// and compares them field by field with the result channel. Depends on tga_pkg.
module tga_decode_checker import tga_pkg::*; #(
  parameter int PIXEL_COUNT_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  input  logic     src_stall,
  input  tga_in_t  src_data,
  input  logic     res_valid,
  input  logic     res_stall,
  input  tga_out_t res_data,
  output int       results_owed,
  output int       mismatch_count
);

  typedef enum logic [2:0] {
    SEEK_SIG, READ_HDR, READ_PKT, READ_PIXEL, IMG_DONE, IMG_FAILED
  } parse_phase_t;

  parse_phase_t    phase;
  logic [4:0]      hdr_pos;
  logic [1:0]      sig_kind;
  logic [15:0]     img_w;
  logic [15:0]     img_h;
  logic            deep;
  logic [31:0]     pix_left;
  logic [7:0]      pkt_left;
  logic            pkt_repeat;
  logic [3:0][7:0] pix_bytes;
  logic [1:0]      byte_pos;
  tga_out_t        results_due[$];

  task automatic clear_parser();
    phase      = SEEK_SIG;
    hdr_pos    = '0;
    sig_kind   = SK_BOTH;
    img_w      = '0;
    img_h      = '0;
    deep       = 1'b0;
    pix_left   = '0;
    pkt_left   = '0;
    pkt_repeat = 1'b0;
    pix_bytes  = '0;
    byte_pos   = '0;
  endtask

  // image fields always mirror the current registers; color only on runs
  function automatic tga_out_t result_for(input logic [1:0] kind, input logic [7:0] count,
                                          input logic [1:0] code, input logic last);
    tga_out_t r;
    r = '0;
    r.kind          = kind;
    r.image_width   = img_w;
    r.image_height  = img_h;
    r.has_alpha     = deep;
    r.is_compressed = (sig_kind == SK_RLE);
    if (kind == KIND_RUN) begin
      r.blue  = pix_bytes[0];
      r.green = pix_bytes[1];
      r.red   = pix_bytes[2];
      r.alpha = deep ? pix_bytes[3] : 8'd0;
    end
    r.repeat_count = count;
    r.error_code   = code;
    r.last         = last;
    return r;
  endfunction

  task automatic abort_image(input logic [1:0] code);
    phase = IMG_FAILED;
    results_due.push_back(result_for(KIND_ERROR, 8'd0, code, 1'b0));
  endtask

  task automatic decode_byte(input tga_in_t beat);
    logic [7:0]  b;
    logic [3:0]  pos;
    logic [63:0] area;
    logic [7:0]  n;
    logic        fin;
    b = beat.data_byte;
    if (beat.start_of_file) clear_parser();
    case (phase)
      SEEK_SIG: begin
        pos = hdr_pos[3:0];
        if (pos < SIG_LEN) begin
          if (b != ((pos == SIG_TYPE_POS) ? SIG_PLAIN_TYPE : 8'd0)) sig_kind &= ~SK_PLAIN;
          if (b != ((pos == SIG_TYPE_POS) ? SIG_RLE_TYPE : 8'd0)) sig_kind &= ~SK_RLE;
        end
        hdr_pos = hdr_pos + 5'd1;
        if (pos >= SIG_LAST_POS) begin
          if (sig_kind == SK_NONE) begin
            abort_image(ERR_SIGNATURE);
          end else begin
            phase   = READ_HDR;
            hdr_pos = HDR_WIDTH_LO;
          end
        end
      end
      READ_HDR: begin
        case (hdr_pos)
          HDR_WIDTH_LO: begin
            img_w   = {8'd0, b};
            hdr_pos = hdr_pos + 5'd1;
          end
          HDR_WIDTH_HI: begin
            img_w[15:8] = b;
            hdr_pos     = hdr_pos + 5'd1;
          end
          HDR_HEIGHT_LO: begin
            img_h   = {8'd0, b};
            hdr_pos = hdr_pos + 5'd1;
          end
          HDR_HEIGHT_HI: begin
            img_h[15:8] = b;
            hdr_pos     = hdr_pos + 5'd1;
          end
          HDR_DEPTH: begin
            area    = img_w * img_h;
            hdr_pos = HDR_DESC;
            if (img_w == 0 || img_h == 0 || (b != BPP_24 && b != BPP_32) ||
                area > ((64'd1 << PIXEL_COUNT_BITS) - 64'd1)) begin
              abort_image(ERR_HEADER);
            end else begin
              deep     = (b == BPP_32);
              pix_left = area[31:0];
              results_due.push_back(result_for(KIND_HEADER, 8'd0, ERR_NONE, 1'b0));
            end
          end
          default: begin
            // descriptor byte: pixel data starts next
            byte_pos   = '0;
            pkt_repeat = 1'b0;
            pkt_left   = '0;
            phase      = (sig_kind == SK_RLE) ? READ_PKT : READ_PIXEL;
          end
        endcase
      end
      READ_PKT: begin
        if (b < PKT_REPEAT_FLAG) begin
          pkt_repeat = 1'b0;
          pkt_left   = b + 8'd1;
        end else begin
          pkt_repeat = 1'b1;
          pkt_left   = b - PKT_REPEAT_BIAS;
        end
        byte_pos = '0;
        phase    = READ_PIXEL;
      end
      READ_PIXEL: begin
        pix_bytes[byte_pos] = b;
        byte_pos = byte_pos + 2'd1;
        if (byte_pos == 2'd0 || (!deep && byte_pos == 2'd3)) begin
          byte_pos = '0;
          if (sig_kind != SK_RLE) begin
            pix_left = pix_left - 32'd1;
            fin = (pix_left == 0);
            if (fin) phase = IMG_DONE;
            results_due.push_back(result_for(KIND_RUN, 8'd1, ERR_NONE, fin));
          end else if (pkt_repeat) begin
            n = pkt_left;
            if (n > pix_left) begin
              abort_image(ERR_OVERRUN);
            end else begin
              pix_left = pix_left - n;
              pkt_left = '0;
              fin = (pix_left == 0);
              phase = fin ? IMG_DONE : READ_PKT;
              results_due.push_back(result_for(KIND_RUN, n, ERR_NONE, fin));
            end
          end else if (pix_left == 0) begin
            abort_image(ERR_OVERRUN);
          end else begin
            // raw pixel; image end only counts when the packet ends with it
            pix_left = pix_left - 32'd1;
            pkt_left = pkt_left - 8'd1;
            fin = 1'b0;
            if (pkt_left == 0) begin
              fin = (pix_left == 0);
              phase = fin ? IMG_DONE : READ_PKT;
            end
            results_due.push_back(result_for(KIND_RUN, 8'd1, ERR_NONE, fin));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    tga_out_t want;
    if (rst) begin
      clear_parser();
      results_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (results_due.size() == 0) begin
          $error("result beat with none expected (kind %0d)", res_data.kind);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("kind", want.kind, res_data.kind);
          compare_field("image_width", want.image_width, res_data.image_width);
          compare_field("image_height", want.image_height, res_data.image_height);
          compare_field("has_alpha", want.has_alpha, res_data.has_alpha);
          compare_field("is_compressed", want.is_compressed, res_data.is_compressed);
          compare_field("red", want.red, res_data.red);
          compare_field("green", want.green, res_data.green);
          compare_field("blue", want.blue, res_data.blue);
          compare_field("alpha", want.alpha, res_data.alpha);
          compare_field("repeat_count", want.repeat_count, res_data.repeat_count);
          compare_field("error_code", want.error_code, res_data.error_code);
          compare_field("last", want.last, res_data.last);
        end
      end
      if (src_valid && !src_stall) decode_byte(src_data);
    end
    results_owed = results_due.size();
  end

endmodule

/* verif/tb_tga_rle_image_decoder_unit.sv */
`timescale 1ns / 1ps
// Top of the TGA RLE decoder testbench: builds TGA byte streams, drives them
// with random gaps and stalls, and reports the verdict. Needs tga_pkg, the RTL
// and tga_decode_checker.
module tb_tga_rle_image_decoder_unit;
  import tga_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung.
  // Gaps at 87% idle/stall stay far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int BYTES_PER_PHASE = 190;

  // How a generated file deviates from a well-formed image
  typedef enum logic [2:0] {CLEAN, BAD_SIG, BAD_HDR, OVERRUN, CUT_SHORT} file_flaw_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  tga_in_t  src_data = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  tga_out_t res_data;

  int         send_idle = 0;   // percent of cycles the byte source holds off
  int         recv_stall = 0;  // percent of cycles the result sink stalls
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  int         results_owed;
  int         mismatch_count;
  logic [7:0] image_q[$];      // bytes of the file being built

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tga_rle_image_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  tga_decode_checker u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .src_valid      (src_valid),
    .src_stall      (src_stall),
    .src_data       (src_data),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res_data       (res_data),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  // Result sink back-pressure, redrawn every cycle
  always @(negedge clk) res_stall <= ($urandom_range(99) < recv_stall);

  // Hang detection: any beat on either side restarts the count
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL tga_rle_image_decoder_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One stored pixel: B, G, R (, A); extremes show up often
  task automatic push_pixel(input bit deep);
    repeat (deep ? 4 : 3)
      case ($urandom_range(7))
        0: image_q.push_back(8'h00);
        1: image_q.push_back(8'hFF);
        default: image_q.push_back(8'($urandom_range(255)));
      endcase
  endtask

  // Assemble a whole file in image_q: signature, 6-byte header, pixel data,
  // then the flaw (if any) and a few trailing bytes the parser must drop.
  task automatic build_file(input bit rle, input bit deep, input logic [15:0] w,
                            input logic [15:0] h, input file_flaw_t flaw);
    int          pos;
    int          n;
    int          keep;
    longint      left;
    logic [7:0]  depth;
    logic [7:0]  bad;
    logic [7:0]  pkt;
    bit          rep;
    image_q.delete();
    for (pos = 0; pos < SIG_LEN; pos++)
      image_q.push_back((pos == SIG_TYPE_POS) ? (rle ? SIG_RLE_TYPE : SIG_PLAIN_TYPE) : 8'd0);
    if (flaw == BAD_SIG) begin
      // one byte off; the type byte must match neither form
      pos = int'($urandom_range(SIG_LEN - 1));
      do bad = 8'($urandom_range(255));
      while (bad == image_q[pos] ||
             (pos == SIG_TYPE_POS && (bad == SIG_PLAIN_TYPE || bad == SIG_RLE_TYPE)));
      image_q[pos] = bad;
    end
    depth = deep ? BPP_32 : BPP_24;
    if (flaw == BAD_HDR) begin
      case ($urandom_range(2))
        0: w = '0;
        1: h = '0;
        default: begin
          do depth = 8'($urandom_range(255));
          while (depth == BPP_24 || depth == BPP_32);
        end
      endcase
    end
    image_q.push_back(w[7:0]);
    image_q.push_back(w[15:8]);
    image_q.push_back(h[7:0]);
    image_q.push_back(h[15:8]);
    image_q.push_back(depth);
    image_q.push_back(8'($urandom_range(255)));  // descriptor, ignored
    left = longint'(w) * longint'(h);
    if (flaw == BAD_SIG || flaw == BAD_HDR) begin
      // nothing after a rejected header is parsed
    end else if (left > 300) begin
      // huge image: only a taste of pixel data before the file is cut
      repeat ($urandom_range(4, 20)) image_q.push_back(8'($urandom_range(255)));
    end else if (rle) begin
      while (left > 0) begin
        rep = 1'($urandom_range(1));
        n = (rep && $urandom_range(3) == 0) ? 128 : int'($urandom_range(1, 8));
        if (n >= left) begin
          // last packet; an overrun makes it longer than what is left
          n = (flaw == OVERRUN) ? int'(left) + int'($urandom_range(1, 3)) : int'(left);
          if (n > 128) n = 128;
        end
        pkt = rep ? 8'(n + PKT_REPEAT_BIAS) : 8'(n - 1);
        image_q.push_back(pkt);
        if (rep) push_pixel(deep);
        else repeat (n) push_pixel(deep);
        left -= n;
      end
    end else begin
      repeat (left + ((flaw == OVERRUN) ? $urandom_range(1, 2) : 0)) push_pixel(deep);
    end
    if (flaw == CUT_SHORT && image_q.size() > 1) begin
      // big images keep their header so its extreme sizes get reported
      keep = int'($urandom_range((left > 300) ? 18 : 1, image_q.size() - 1));
      while (image_q.size() > keep) void'(image_q.pop_back());
    end else begin
      repeat ($urandom_range(2)) image_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Drive image_q one beat at a time; entered and left at a falling edge.
  // The payload holds still while valid is up and the block stalls.
  task automatic send_file(input bit flagged);
    tga_in_t beat;
    for (int i = 0; i < image_q.size(); i++) begin
      beat.data_byte     = image_q[i];
      beat.start_of_file = flagged && (i == 0);
      while ($urandom_range(99) < send_idle) begin
        src_valid <= 1'b0;
        @(negedge clk);
      end
      src_valid <= 1'b1;
      src_data  <= beat;
      do @(posedge clk); while (src_stall);
      @(negedge clk);
      bytes_sent++;
    end
  endtask

  initial begin : stimulus
    int         ph;
    int         sel;
    bit         rle;
    bit         deep;
    logic [15:0] w;
    logic [15:0] h;
    file_flaw_t flaw;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files, no idling: RLE 32bpp single pixel, plain file
    // with pixels past the end, bad signature, maximum header then restart
    // mid-data, bad header, RLE packet running past the image.
    build_file(1'b1, 1'b1, 16'd1, 16'd1, CLEAN);
    send_file(1'b1);
    build_file(1'b0, 1'b0, 16'd2, 16'd1, OVERRUN);
    send_file(1'b1);
    build_file(1'b1, 1'b0, 16'd3, 16'd1, BAD_SIG);
    send_file(1'b1);
    build_file(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, CUT_SHORT);
    send_file(1'b1);
    build_file(1'b1, 1'b0, 16'd2, 16'd2, BAD_HDR);
    send_file(1'b1);
    build_file(1'b1, 1'b1, 16'd3, 16'd2, OVERRUN);
    send_file(1'b1);

    // Random files across four flow-control phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      while (bytes_sent < (ph + 1) * BYTES_PER_PHASE) begin
        sel  = int'($urandom_range(99));
        rle  = 1'($urandom_range(1));
        deep = 1'($urandom_range(1));
        w    = 16'($urandom_range(1, 6));
        h    = 16'($urandom_range(1, 4));
        flaw = CLEAN;
        if (sel < 8) begin
          flaw = BAD_SIG;
        end else if (sel < 16) begin
          flaw = BAD_HDR;
          if (sel < 12) begin
            w = 16'($urandom_range(65535));
            h = 16'($urandom_range(65535));
          end
        end else if (sel < 26) begin
          flaw = OVERRUN;
        end else if (sel < 34) begin
          flaw = CUT_SHORT;
        end else if (sel < 40) begin
          // full-range dimensions; header only, then cut
          flaw = CUT_SHORT;
          w = 16'($urandom_range(65535));
          h = 16'($urandom_range(65535));
        end else if (sel < 48) begin
          // long RLE line so full 128-pixel repeat packets fit
          rle = 1'b1;
          w = 16'($urandom_range(129, 260));
          h = 16'd1;
        end
        build_file(rle, deep, w, h, flaw);
        // now and then a file without its start mark: dropped or continued
        send_file($urandom_range(19) != 0);
      end
    end
    src_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("PASS tga_rle_image_decoder_unit");
    else
      $display("FAIL tga_rle_image_decoder_unit");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tga_pkg.sv
rtl/tga_parser.sv
rtl/tga_queue.sv
rtl/tga_out_stage.sv
rtl/tga_rle_image_decoder_unit.sv
rtl/tga_checker.sv
verif/tga_decode_checker.sv
verif/tb_tga_rle_image_decoder_unit.sv
